[rtl/core/twdf_pkg.sv]
package twdf_pkg;

  localparam int HOLD_DEPTH  = 7;  // bytes looked at per step
  localparam int KEEP_DEPTH  = 6;  // bytes held between steps
  localparam int SHORT_LEN   = 6;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] cnt_t;

  localparam logic [SHORT_LEN*8-1:0]  WORD_SHORT = "cookie";
  localparam logic [HOLD_DEPTH*8-1:0] WORD_LONG  = "biscuit";

  localparam byte_t CH_UPPER_A = 8'h41;
  localparam byte_t CH_UPPER_Z = 8'h5a;
  localparam byte_t CH_LOWER_A = 8'h61;

  // one queue entry: what the back end has to send for one accepted byte
  typedef struct packed {
    logic                     emit;       // send emit_byte first
    byte_t                    emit_byte;
    logic                     flush;      // then flush fbytes, or an empty marker
    cnt_t                     fcnt;
    byte_t [KEEP_DEPTH-1:0]   fbytes;
  } qent_t;

  function automatic byte_t fold_case(input byte_t b);
    byte_t r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b - CH_UPPER_A + CH_LOWER_A;
    end
    return r;
  endfunction

  function automatic byte_t short_char(input int k);
    return WORD_SHORT[(SHORT_LEN-1-k)*8 +: 8];
  endfunction

  function automatic byte_t long_char(input int k);
    return WORD_LONG[(HOLD_DEPTH-1-k)*8 +: 8];
  endfunction

endpackage

[rtl/core/two_word_deletion_filter_top.sv]
// Each result passes through the entry queue and is then registered in the output register.
// Throughput: one byte in and one result out per cycle, unless q_full or out_stall holds.
// A flush of k held bytes leaves as k results at the output (one for an empty marker);
// the entry queue (QUEUE_DEPTH entries) lets input continue meanwhile.
// Reset (rst, synchronous, active high) empties the window, the queue and the output.
module two_word_deletion_filter_top import twdf_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  // input channel
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_byte,
  input  logic  in_last,
  // result channel
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_last,
  output logic  out_empty
);

  // Front end: keeps the last up to six unsent bytes, appends each incoming
  // byte, checks "biscuit" over all seven and "cookie" over the tail, and
  // decides what leaves. Only bytes that cause output push a queue entry:
  // an entry carries the byte pushed out of the window (if any) and, for a
  // last byte, a snapshot of what is still held.
  qent_t q_wdata, q_head;
  logic  q_push, q_pop, q_empty, q_full;

  twdf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Short queue between the two halves so each side stalls on its own.
  twdf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back end: walks one entry per transfer sequence - the pushed-out byte,
  // then the flushed bytes oldest first with out_last on the final one, or
  // an empty end marker when nothing was held at the flush.
  twdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_empty (out_empty)
  );

endmodule

[rtl/core/twdf_front.sv]
module twdf_front import twdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_byte,
  input  logic  in_last,
  input  logic  q_full,
  output logic  q_push,
  output qent_t q_data
);

  byte_t held [KEEP_DEPTH];
  cnt_t  cnt;

  byte_t win [HOLD_DEPTH];
  byte_t post [KEEP_DEPTH];
  cnt_t  post_cnt;
  logic  accept, full7, hit_long, hit_c6, hit_c7, hit_short;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign full7    = (cnt == cnt_t'(KEEP_DEPTH));

  // window with the new byte appended at position cnt
  always_comb begin
    for (int k = 0; k < KEEP_DEPTH; k++) begin
      win[k] = (cnt == cnt_t'(k)) ? in_byte : held[k];
    end
    win[HOLD_DEPTH-1] = in_byte;
  end

  always_comb begin
    hit_long = full7;
    hit_c7   = full7;
    hit_c6   = (cnt == cnt_t'(SHORT_LEN-1));
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      if (fold_case(win[k]) != long_char(k)) hit_long = 1'b0;
    end
    for (int k = 0; k < SHORT_LEN; k++) begin
      if (fold_case(win[k]) != short_char(k))   hit_c6 = 1'b0;
      if (fold_case(win[k+1]) != short_char(k)) hit_c7 = 1'b0;
    end
    hit_short = hit_c6 || hit_c7;
  end

  // held bytes after the match step
  always_comb begin
    for (int k = 0; k < KEEP_DEPTH; k++) begin
      post[k] = full7 ? win[k+1] : win[k];
    end
    if (hit_long || hit_short) begin
      post_cnt = '0;
    end else if (full7) begin
      post_cnt = cnt_t'(KEEP_DEPTH);
    end else begin
      post_cnt = cnt + cnt_t'(1);
    end
  end

  always_comb begin
    q_data.emit      = full7 && !hit_long;
    q_data.emit_byte = held[0];
    q_data.flush     = in_last;
    q_data.fcnt      = post_cnt;
    for (int k = 0; k < KEEP_DEPTH; k++) begin
      q_data.fbytes[k] = post[k];
    end
    q_push = accept && (q_data.emit || q_data.flush);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < KEEP_DEPTH; k++) begin
        held[k] <= post[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= in_last ? cnt_t'(0) : post_cnt;
    end
  end

endmodule

[rtl/core/twdf_queue.sv]
module twdf_queue import twdf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t wdata,
  input  logic  pop,
  output qent_t head,
  output logic  empty,
  output logic  full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t           mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == CW'(DEPTH));
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

[rtl/core/twdf_back.sv]
module twdf_back import twdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  qent_t head,
  input  logic  q_empty,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_last,
  output logic  out_empty
);

  logic  emit_done;
  cnt_t  fidx;

  logic  load, emit_phase, ent_done;
  byte_t r_byte;
  logic  r_last, r_empty;

  assign load = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    emit_phase = head.emit && !emit_done;
    if (emit_phase) begin
      r_byte   = head.emit_byte;
      r_last   = 1'b0;
      r_empty  = 1'b0;
      ent_done = !head.flush;
    end else if (head.fcnt == '0) begin
      r_byte   = '0;
      r_last   = 1'b1;
      r_empty  = 1'b1;
      ent_done = 1'b1;
    end else begin
      r_byte   = head.fbytes[fidx];
      r_last   = (fidx == head.fcnt - cnt_t'(1));
      r_empty  = 1'b0;
      ent_done = r_last;
    end
    q_pop = load && ent_done;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= r_byte;
      out_last  <= r_last;
      out_empty <= r_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit_done <= 1'b0;
      fidx      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (ent_done) begin
          emit_done <= 1'b0;
          fidx      <= '0;
        end else if (emit_phase) begin
          emit_done <= 1'b1;
        end else begin
          fidx <= fidx + cnt_t'(1);
        end
      end
    end
  end

endmodule

[rtl/core/twdf_checker.sv]
module twdf_props import twdf_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_stall,
  input byte_t in_byte,
  input logic  in_last,
  input logic  out_valid,
  input logic  out_stall,
  input byte_t out_byte,
  input logic  out_last,
  input logic  out_empty
);

  // a stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_empty))
    else $error("stalled result changed");

  // empty marker is always the end of a stream
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last)
    else $error("empty marker without last");

  // empty marker carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_byte == 8'h00)
    else $error("empty marker with data");

  // reset clears the output valid flag
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind two_word_deletion_filter_top twdf_props u_chk (.*);

[verif/twdf_checker.sv]
module twdf_checker import twdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_stall,
  input  byte_t in_byte,
  input  logic  in_last,
  input  logic  out_valid,
  input  logic  out_stall,
  input  byte_t out_byte,
  input  logic  out_last,
  input  logic  out_empty,
  output int    mismatches,
  output int    waiting,
  output int    bytes_in,
  output int    results_out,
  output int    cookies,
  output int    biscuits,
  output int    blanks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    byte_t data;
    logic  fin;
    logic  blank;
  } kept_t;

  kept_t kept_q[$];          // filtered bytes still owed by the block
  byte_t held [HOLD_DEPTH];  // look-behind window, oldest at 0
  int    held_n;

  function automatic byte_t to_lower(input byte_t b);
    if (b >= "A" && b <= "Z") begin
      return b | 8'h20;
    end
    return b;
  endfunction

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // One accepted byte: append, test both words at the tail, shift or flush.
  task automatic filter_step(input byte_t b, input logic fin);
    logic long_hit;
    logic short_hit;
    int   k;
    held[held_n] = b;
    held_n++;
    long_hit  = (held_n == HOLD_DEPTH);
    short_hit = (held_n >= SHORT_LEN);
    for (k = 0; k < HOLD_DEPTH; k++) begin
      if (long_hit && to_lower(held[k]) != WORD_LONG[(HOLD_DEPTH-1-k)*8 +: 8]) begin
        long_hit = 1'b0;
      end
    end
    for (k = 0; k < SHORT_LEN; k++) begin
      if (short_hit &&
          to_lower(held[held_n-SHORT_LEN+k]) != WORD_SHORT[(SHORT_LEN-1-k)*8 +: 8]) begin
        short_hit = 1'b0;
      end
    end
    if (long_hit) begin
      held_n = 0;
      biscuits++;
    end else if (short_hit) begin
      if (held_n == HOLD_DEPTH) begin
        kept_q.push_back(kept_t'{held[0], 1'b0, 1'b0});
      end
      held_n = 0;
      cookies++;
    end else if (held_n == HOLD_DEPTH) begin
      kept_q.push_back(kept_t'{held[0], 1'b0, 1'b0});
      for (k = 1; k < HOLD_DEPTH; k++) begin
        held[k-1] = held[k];
      end
      held_n--;
    end
    if (fin) begin
      if (held_n == 0) begin
        kept_q.push_back(kept_t'{8'h00, 1'b1, 1'b1});
        blanks++;
      end else begin
        for (k = 0; k < held_n; k++) begin
          kept_q.push_back(kept_t'{held[k], logic'(k == held_n - 1), 1'b0});
        end
      end
      held_n = 0;
    end
  endtask

  always @(posedge clk) begin
    kept_t want;
    if (rst) begin
      held_n = 0;
      kept_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (kept_q.size() == 0) begin
          report($sformatf("unexpected result byte=%02h last=%0b empty=%0b",
                           out_byte, out_last, out_empty));
        end else begin
          want = kept_q.pop_front();
          if (out_byte !== want.data) begin
            report($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          end
          if (out_last !== want.fin) begin
            report($sformatf("out_last %0b, want %0b (byte %02h)", out_last, want.fin,
                             want.data));
          end
          if (out_empty !== want.blank) begin
            report($sformatf("out_empty %0b, want %0b (byte %02h)", out_empty, want.blank,
                             want.data));
          end
        end
      end
      if (in_valid && !in_stall) begin
        bytes_in++;
        filter_step(in_byte, in_last);
      end
    end
    waiting = kept_q.size();
  end

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twdf_pkg::*;

  // Stimulus sizing. Directed part is ~26 bytes, the rest is random streams.
  localparam int ITEM_TARGET  = 470;
  // Worst case is far below this: ~470 bytes, up to 7 results each, each
  // result behind a receiver stall run, plus gaps.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 80;   // receiver hold-off, fills window + queue
  localparam int HOLD_TRIGGER = 150;  // bytes in before the hold-off starts
  localparam int DRAIN_TAIL   = 20;   // output register plus queue, with margin

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  byte_t in_byte;
  logic  in_last;
  logic  out_valid;
  logic  out_stall;
  byte_t out_byte;
  logic  out_last;
  logic  out_empty;

  int mismatches;
  int waiting;
  int bytes_in;
  int results_out;
  int cookies;
  int biscuits;
  int blanks;

  int    sent;        // bytes transferred in by the stimulus
  int    burst_left;  // bytes left in the current sender burst
  int    streams;
  int    cycles;
  byte_t stream_q[$];

  two_word_deletion_filter_top u_top (.*);

  // Watches both channels, predicts the filtered stream and compares.
  twdf_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: anything still pending here means the block hung or lost data.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("two_word_deletion_filter_top verification failed");
    $finish;
  end

  // Flip a lower-case letter to upper case half the time; matching must fold it.
  function automatic byte_t mixed_case(input byte_t c);
    if ($urandom_range(0, 1) != 0) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Append w[from .. upto-1] in random case: whole words, prefixes, suffixes.
  task automatic add_word(input string w, input int from, input int upto);
    int k;
    for (k = from; k < upto; k++) begin
      stream_q.push_back(mixed_case(byte_t'(w[k])));
    end
  endtask

  // One transfer on the input channel. Bursts of random length, with a random
  // gap (sometimes none) before each new burst. Valid drops only in the gap,
  // so a held payload never changes while stalled.
  task automatic send(input byte_t b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send(byte_t'(s[k]), fin && (k == s.len() - 1));
    end
  endtask

  // A random stream is mostly word material (whole words, prefixes, tails,
  // single letters of both words) so that the window sees near misses and
  // back-to-back hits; the rest is raw noise over the full byte range.
  // Most streams close with the last flag, a few run on into the next one.
  task automatic send_random_stream();
    int    pieces;
    int    p;
    int    k;
    int    cut;
    logic  closed;
    string letters;
    letters = "cobiskuet";
    stream_q.delete();
    pieces = $urandom_range(1, 4);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_word("cookie", 0, 6);
        end
        2, 3: begin
          add_word("biscuit", 0, 7);
        end
        4: begin
          add_word("cookie", 0, $urandom_range(1, 5));
        end
        5: begin
          add_word("biscuit", 0, $urandom_range(1, 6));
        end
        6: begin
          cut = $urandom_range(1, 6);
          add_word("biscuit", cut, 7);
        end
        7: begin
          cut = $urandom_range(0, letters.len() - 1);
          add_word(letters, cut, cut + 1);
        end
        default: begin
          repeat ($urandom_range(1, 4)) stream_q.push_back(byte_t'($urandom_range(0, 255)));
        end
      endcase
    end
    closed = ($urandom_range(0, 9) != 0);
    for (k = 0; k < stream_q.size(); k++) begin
      send(stream_q[k], closed && (k == stream_q.size() - 1));
    end
    streams++;
  endtask

  // Receiver: stall pattern changes after each random span, including phases
  // with no stall at all. Once, after enough input, it holds off for a long
  // stretch while the sender keeps offering, so the block backs up to in_stall.
  initial begin
    int   span;
    int   mode;
    int   k;
    logic long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (!long_done && bytes_in >= HOLD_TRIGGER) begin
        long_done = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end
      mode = $urandom_range(0, 4);
      span = $urandom_range(20, 150);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          3: out_stall <= ((k % 5) < 2);
          default: out_stall <= ((k / 8) % 2 == 1);
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    in_last    = 1'b0;
    sent       = 0;
    burst_left = 0;
    streams    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a word that ends the stream leaves only an empty end marker.
    send_text("cookie", 1'b1);
    send_text("BiScUiT", 1'b1);
    // Seventh byte ahead of a tail match is emitted, then the empty marker.
    send_text("qCOOKIE", 1'b1);
    // Case-fold boundaries: just outside 'A'..'Z' and 'a'..'z'.
    send_text("@[`{", 1'b1);
    // Byte extremes, in one two-byte stream.
    send(8'h00, 1'b0);
    send(8'hff, 1'b1);
    streams += 5;

    while (sent < ITEM_TARGET) begin
      send_random_stream();
    end
    in_valid <= 1'b0;

    // Drain: all predicted results back, then a DRAIN_TAIL wait for strays.
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("covered %0d bytes in %0d streams, %0d results checked", bytes_in, streams,
             results_out);
    $display("deleted %0d cookie and %0d biscuit, %0d empty end markers, %0d mismatches",
             cookies, biscuits, blanks, mismatches);
    if (mismatches == 0) begin
      $display("two_word_deletion_filter_top verification clean");
    end else begin
      $display("two_word_deletion_filter_top verification failed");
    end
    $finish;
  end

endmodule
